### src/depth_row_noise_classifier_defines.svh
// ----------------------------------------------------------------------------
// depth row noise classifier assertion macros
// shared checks, written against clk and arst_n of the including module
// ----------------------------------------------------------------------------
`ifndef DEPTH_ROW_NOISE_CLASSIFIER_DEFINES_SVH
`define DEPTH_ROW_NOISE_CLASSIFIER_DEFINES_SVH

// antecedent true implies consequent in the same cycle
`define DRNC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drnc implication violated");

// condition never holds
`define DRNC_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("drnc forbidden condition");

`endif

### src/drnc_pkg.sv
// ----------------------------------------------------------------------------
// drnc_pkg
// types and constants of the depth row noise classifier
// ----------------------------------------------------------------------------
`default_nettype none

package drnc_pkg;

	localparam int DEPTH_W     = 16;
	localparam int ROW_W       = 10;
	localparam int SUM_W       = 28;
	localparam int RUN_W       = 12;
	localparam int NOISY_W     = 11;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 28;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
	localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
	localparam logic [NOISY_W-1:0] NOISY_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE          = 3'd0,
		CFG_STEP_LIMIT      = 3'd1,
		CFG_RUN_LIMIT       = 3'd2,
		CFG_ROW_SUM_LIMIT   = 3'd3,
		CFG_NOISY_RUN_LIMIT = 3'd4,
		CFG_EXTRA_ROWS      = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic               enable;
		logic [DEPTH_W-1:0] step_limit;
		logic [RUN_W-1:0]   run_limit;
		logic [SUM_W-1:0]   row_sum_limit;
		logic [ROW_W-1:0]   noisy_run_limit;
		logic [ROW_W-1:0]   extra_rows;
	} cfg_t;

	// summary of one finished row, handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0] row_sum;
		logic             row_stopped;
		logic             eof;
		logic             enable;
	} row_rec_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QPTR_W:0]   count;
	} queue_stat_t;

endpackage

`default_nettype wire

### src/drnc_stream_if.sv
// ----------------------------------------------------------------------------
// drnc stream interfaces
// pixel request channel and row result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface drnc_pix_if;
	logic                        valid;
	logic                        ready;
	logic [drnc_pkg::DEPTH_W-1:0] depth_mm;
	logic                        end_of_row;
	logic                        end_of_frame;

	modport source(output valid, depth_mm, end_of_row, end_of_frame, input ready);
	modport sink(input valid, depth_mm, end_of_row, end_of_frame, output ready);
endinterface

interface drnc_row_if;
	logic                      valid;
	logic                      ready;
	logic [drnc_pkg::ROW_W-1:0] row_number;
	logic                      row_blank;
	logic                      cut_found;
	logic [drnc_pkg::ROW_W-1:0] cut_start_row;
	logic                      last;

	modport source(output valid, row_number, row_blank, cut_found, cut_start_row, last,
		input ready);
	modport sink(input valid, row_number, row_blank, cut_found, cut_start_row, last,
		output ready);
endinterface

`default_nettype wire

### src/drnc_front.sv
// ----------------------------------------------------------------------------
// drnc_front
// per-pixel analysis, pushes one summary per finished row
// ----------------------------------------------------------------------------
`default_nettype none

module drnc_front import drnc_pkg::*; #(
	parameter int DEPTH_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	drnc_pix_if.sink pixels,
	input  logic     push_ready,
	output logic     push,
	output row_rec_t push_rec
);

	logic [DEPTH_BITS-1:0] prev_q;
	logic                  have_prev_q;
	logic [SUM_W-1:0]      sum_q;
	logic [RUN_W-1:0]      run_q;
	logic                  stopped_q;

	logic                  accept;
	logic                  row_end;
	logic [DEPTH_BITS-1:0] depth;
	logic                  px_valid;
	logic [DEPTH_BITS:0]   diff;
	logic                  neg;
	logic [DEPTH_BITS-1:0] mag;
	logic [SUM_W:0]        sum_add;
	logic [SUM_W-1:0]      sum_n;
	logic [RUN_W-1:0]      run_n;
	logic                  stopped_n;

	assign pixels.ready = push_ready;
	assign accept       = pixels.valid && pixels.ready;
	assign row_end      = pixels.end_of_row || pixels.end_of_frame;
	assign depth        = pixels.depth_mm[DEPTH_BITS-1:0];
	assign px_valid     = (depth != '0);

	// signed left minus right, one bit wider than the depth
	assign diff    = {1'b0, prev_q} - {1'b0, depth};
	assign neg     = diff[DEPTH_BITS];
	assign mag     = neg ? DEPTH_BITS'(-diff) : diff[DEPTH_BITS-1:0];
	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(mag);

	always_comb begin
		sum_n     = sum_q;
		run_n     = run_q;
		stopped_n = stopped_q;
		if (cfg.enable && px_valid && have_prev_q && !stopped_q) begin
			sum_n = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
			if (!neg && (16'(mag) > cfg.step_limit) && (run_q != RUN_MAX))
				run_n = run_q + 1'b1;
			if (neg)
				run_n = '0;
			if (run_n > cfg.run_limit)
				stopped_n = 1'b1;
		end
	end

	assign push                 = accept && row_end;
	assign push_rec.row_sum     = sum_n;
	assign push_rec.row_stopped = stopped_n;
	assign push_rec.eof         = pixels.end_of_frame;
	assign push_rec.enable      = cfg.enable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			sum_q       <= '0;
			run_q       <= '0;
			stopped_q   <= 1'b0;
		end else if (accept) begin
			if (row_end) begin
				prev_q      <= '0;
				have_prev_q <= 1'b0;
				sum_q       <= '0;
				run_q       <= '0;
				stopped_q   <= 1'b0;
			end else if (cfg.enable) begin
				prev_q      <= depth;
				have_prev_q <= px_valid;
				sum_q       <= sum_n;
				run_q       <= run_n;
				stopped_q   <= stopped_n;
			end
		end
	end

endmodule

`default_nettype wire

### src/drnc_queue.sv
// ----------------------------------------------------------------------------
// drnc_queue
// short fifo of row summaries between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module drnc_queue import drnc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  row_rec_t    push_rec,
	input  logic        pop,
	output row_rec_t    head_rec,
	output queue_stat_t stat
);

	row_rec_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.count = count_q;
	assign stat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head_rec   = mem_q[rd_ptr_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

### src/drnc_back.sv
// ----------------------------------------------------------------------------
// drnc_back
// noisy row run tracking, frame cut decision and result register
// ----------------------------------------------------------------------------
`default_nettype none

module drnc_back import drnc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       rec_valid,
	input  row_rec_t   rec,
	output logic       pop,
	drnc_row_if.source rows
);

	logic [NOISY_W-1:0] noisy_q;
	logic [ROW_W-1:0]   row_q;
	logic               cut_q;
	logic               out_valid_q;
	logic [ROW_W-1:0]   out_row_q;
	logic               out_blank_q;
	logic               out_cut_q;
	logic [ROW_W-1:0]   out_start_q;
	logic               out_last_q;

	logic [NOISY_W-1:0] noisy_n;
	logic               cut_n;
	logic               blank;
	logic               cut_hit;
	logic [ROW_W-1:0]   start;
	logic [RUN_W-1:0]   back_rows;

	assign pop = rec_valid && (!out_valid_q || rows.ready);

	always_comb begin
		noisy_n   = noisy_q;
		cut_n     = cut_q;
		blank     = 1'b0;
		cut_hit   = 1'b0;
		start     = '0;
		back_rows = '0;
		if (!rec.enable) begin
			noisy_n = '0;
			cut_n   = 1'b0;
		end else if (cut_q) begin
			blank = 1'b1;
		end else begin
			if (rec.row_sum > cfg.row_sum_limit) begin
				if (noisy_q != NOISY_MAX)
					noisy_n = noisy_q + 1'b1;
			end else begin
				noisy_n = '0;
			end
			blank = rec.row_stopped;
			if (noisy_n > NOISY_W'(cfg.noisy_run_limit)) begin
				back_rows = RUN_W'(noisy_n - 1'b1) + RUN_W'(cfg.extra_rows);
				start     = (back_rows > RUN_W'(row_q)) ? '0 : row_q - back_rows[ROW_W-1:0];
				cut_hit   = 1'b1;
				blank     = 1'b1;
				cut_n     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noisy_q     <= '0;
			row_q       <= '0;
			cut_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (rec.eof) begin
					noisy_q <= '0;
					row_q   <= '0;
					cut_q   <= 1'b0;
				end else begin
					noisy_q <= noisy_n;
					row_q   <= row_q + 1'b1;
					cut_q   <= cut_n;
				end
			end else if (rows.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_row_q   <= row_q;
			out_blank_q <= blank;
			out_cut_q   <= cut_hit;
			out_start_q <= start;
			out_last_q  <= rec.eof;
		end
	end

	assign rows.valid         = out_valid_q;
	assign rows.row_number    = out_row_q;
	assign rows.row_blank     = out_blank_q;
	assign rows.cut_found     = out_cut_q;
	assign rows.cut_start_row = out_start_q;
	assign rows.last          = out_last_q;

endmodule

`default_nettype wire

### src/depth_row_noise_classifier.sv
// path: an accepted row-end pixel request writes its row summary into the row queue, then the result register takes it
// throughput: one pixel request per cycle while the row queue is not full; one row result per cycle when rows are taken
// the four-entry row queue lets the pixel side run on while row results are stalled
// reset: arst_n clears all row and frame state and the queue, config returns to defaults
// ----------------------------------------------------------------------------
// depth_row_noise_classifier
// classifies depth rows as noisy and finds the frame cut row from a pixel stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "depth_row_noise_classifier_defines.svh"

module depth_row_noise_classifier import drnc_pkg::*; #(
	parameter int DEPTH_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	drnc_pix_if.sink              pixels,
	drnc_row_if.source            rows,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	// configuration registers
	cfg_t        cfg_q;

	// front to queue
	logic        push;
	row_rec_t    push_rec;

	// queue to back
	logic        pop;
	row_rec_t    head_rec;
	queue_stat_t q_stat;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= 1'b1;
			cfg_q.step_limit      <= 16'd200;
			cfg_q.run_limit       <= 12'd10;
			cfg_q.row_sum_limit   <= 28'd100000;
			cfg_q.noisy_run_limit <= 10'd5;
			cfg_q.extra_rows      <= 10'd0;
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				CFG_ENABLE:          cfg_q.enable          <= wr_data[0];
				CFG_STEP_LIMIT:      cfg_q.step_limit      <= wr_data[DEPTH_W-1:0];
				CFG_RUN_LIMIT:       cfg_q.run_limit       <= wr_data[RUN_W-1:0];
				CFG_ROW_SUM_LIMIT:   cfg_q.row_sum_limit   <= wr_data[SUM_W-1:0];
				CFG_NOISY_RUN_LIMIT: cfg_q.noisy_run_limit <= wr_data[ROW_W-1:0];
				CFG_EXTRA_ROWS:      cfg_q.extra_rows      <= wr_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// front: per-pixel difference sum and step run, one row summary per row end
	drnc_front #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pixels    (pixels),
		.push_ready(!q_stat.full),
		.push      (push),
		.push_rec  (push_rec)
	);

	// row summaries wait here while the result side is stalled
	drnc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.pop     (pop),
		.head_rec(head_rec),
		.stat    (q_stat)
	);

	// back: noisy run count, cut decision, row numbering and result register
	drnc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.rec_valid(!q_stat.empty),
		.rec      (head_rec),
		.pop      (pop),
		.rows     (rows)
	);

	// a cut row is always blanked and its cut never starts after the row itself
	`DRNC_ASSERT_IMPL(a_cut_blanks, rows.valid && rows.cut_found, rows.row_blank)
	`DRNC_ASSERT_IMPL(a_cut_start_le_row, rows.valid && rows.cut_found,
		rows.cut_start_row <= rows.row_number)
	// the queue never reports full and empty together, and never overfills
	`DRNC_ASSERT_NEVER(a_queue_full_empty, q_stat.full && q_stat.empty)
	`DRNC_ASSERT_NEVER(a_push_into_full, push && q_stat.full)

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the depth row noise classifier: pixel requests go
// in through the stream interface, each row verdict coming out is compared
// against a verdict worked out in the bench from the same pixels and settings
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import drnc_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 11;
	// result passes the row queue and the result register after the row end, leave some margin
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int HOLD_CYCLES   = 64;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 200;
	// wide row of alternating extremes, its sum just above the noisy limit
	localparam int WIDE_PIXELS   = 64;
	localparam int WIDE_SUM      = (WIDE_PIXELS - 1) * 65534;
	// more rows than the row counter can hold
	localparam int WRAP_ROWS     = 1030;

	// one row verdict, in the order of the result channel fields
	typedef struct packed {
		logic [ROW_W-1:0] row_number;
		logic             row_blank;
		logic             cut_found;
		logic [ROW_W-1:0] cut_start_row;
		logic             last;
	} row_verdict_t;

	typedef enum {ROW_SMOOTH, ROW_NOISY, ROW_STAIRS, ROW_SPARSE} row_style_t;

	// bench copy of the classifier: settings, row and frame state, verdicts in flight
	class row_verdict_board;
		cfg_t               cfg;
		logic [DEPTH_W-1:0] prev_depth;
		bit                 have_prev;
		logic [SUM_W-1:0]   row_sum;
		logic [RUN_W-1:0]   step_run;
		bit                 row_stopped;
		logic [NOISY_W-1:0] noisy_count;
		logic [ROW_W-1:0]   row_ctr;
		bit                 frame_cut;
		row_verdict_t       pending_rows[$];
		int                 errors;

		function new();
			cfg.enable          = 1'b1;
			cfg.step_limit      = 200;
			cfg.run_limit       = 10;
			cfg.row_sum_limit   = 100000;
			cfg.noisy_run_limit = 5;
			cfg.extra_rows      = 0;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_row();
			prev_depth  = '0;
			have_prev   = 1'b0;
			row_sum     = '0;
			step_run    = '0;
			row_stopped = 1'b0;
		endfunction

		function void clear_frame();
			clear_row();
			noisy_count = '0;
			row_ctr     = '0;
			frame_cut   = 1'b0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_ENABLE:          cfg.enable          = data[0];
				CFG_STEP_LIMIT:      cfg.step_limit      = data[DEPTH_W-1:0];
				CFG_RUN_LIMIT:       cfg.run_limit       = data[RUN_W-1:0];
				CFG_ROW_SUM_LIMIT:   cfg.row_sum_limit   = data[SUM_W-1:0];
				CFG_NOISY_RUN_LIMIT: cfg.noisy_run_limit = data[ROW_W-1:0];
				CFG_EXTRA_ROWS:      cfg.extra_rows      = data[ROW_W-1:0];
				default: ;
			endcase
		endfunction

		// fold one accepted pixel in, queue a verdict when it ends a row
		function void note_pixel(logic [DEPTH_W-1:0] depth, logic eor, logic eof);
			int           diff;
			longint       mag;
			int           back;
			row_verdict_t v;
			if (cfg.enable) begin
				if (depth != 0 && have_prev && !row_stopped && !frame_cut) begin
					diff = int'(prev_depth) - int'(depth);
					mag  = (diff < 0) ? -diff : diff;
					// row sum sticks at its ceiling
					if (longint'(row_sum) + mag > longint'(SUM_MAX))
						row_sum = SUM_MAX;
					else
						row_sum = SUM_W'(longint'(row_sum) + mag);
					if (diff > int'(cfg.step_limit) && step_run != RUN_MAX)
						step_run++;
					// a step back up ends the artifact run
					if (diff < 0)
						step_run = '0;
					if (step_run > cfg.run_limit)
						row_stopped = 1'b1;
				end
				prev_depth = depth;
				have_prev  = (depth != 0);
			end
			if (!eor && !eof)
				return;
			v = '0;
			if (!cfg.enable) begin
				noisy_count = '0;
				frame_cut   = 1'b0;
			end else if (frame_cut) begin
				v.row_blank = 1'b1;
			end else begin
				if (row_sum > cfg.row_sum_limit) begin
					if (noisy_count != NOISY_MAX)
						noisy_count++;
				end else begin
					noisy_count = '0;
				end
				v.row_blank = row_stopped;
				if (noisy_count > cfg.noisy_run_limit) begin
					// cut start reaches back over the noisy run, clamped at row zero
					back = int'(noisy_count) - 1 + int'(cfg.extra_rows);
					v.cut_start_row = (back > int'(row_ctr)) ? '0 : ROW_W'(int'(row_ctr) - back);
					v.cut_found = 1'b1;
					v.row_blank = 1'b1;
					frame_cut   = 1'b1;
				end
			end
			v.row_number = row_ctr;
			v.last       = eof;
			pending_rows.push_back(v);
			if (eof) begin
				clear_frame();
			end else begin
				clear_row();
				row_ctr++;
			end
		endfunction

		function void check_row(row_verdict_t got);
			row_verdict_t want;
			if (pending_rows.size() == 0) begin
				$error("row verdict for row %0d with none pending", got.row_number);
				errors++;
				return;
			end
			want = pending_rows.pop_front();
			if (got.row_number !== want.row_number) begin
				$error("row_number: expected %0d, got %0d", want.row_number, got.row_number);
				errors++;
			end
			if (got.row_blank !== want.row_blank) begin
				$error("row_blank: expected %0d, got %0d", want.row_blank, got.row_blank);
				errors++;
			end
			if (got.cut_found !== want.cut_found) begin
				$error("cut_found: expected %0d, got %0d", want.cut_found, got.cut_found);
				errors++;
			end
			if (got.cut_start_row !== want.cut_start_row) begin
				$error("cut_start_row: expected %0d, got %0d", want.cut_start_row,
					got.cut_start_row);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_rows.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	drnc_pix_if pixels_ch();
	drnc_row_if rows_ch();

	row_verdict_board board;
	int pixel_count = 0;
	// idling switches for the two sides, and the long receiver hold-off
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit long_hold = 1'b0;

	depth_row_noise_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pixels_ch),
		.rows     (rows_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// offer one pixel request from a falling edge, return at the falling edge after it
	// is taken; valid stays high so the next call can follow without a gap
	task automatic send_pixel(logic [DEPTH_W-1:0] depth, bit eor, bit eof);
		int gap;
		if (tx_idle && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 4);
			pixels_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixels_ch.valid        <= 1'b1;
		pixels_ch.depth_mm     <= depth;
		pixels_ch.end_of_row   <= eor;
		pixels_ch.end_of_frame <= eof;
		do @(posedge clk); while (pixels_ch.ready !== 1'b1);
		board.note_pixel(depth, eor, eof);
		pixel_count++;
		@(negedge clk);
	endtask

	// one register write per cycle; caller drops wr_en after the last one
	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		board.set_reg(idx, data);
		@(negedge clk);
	endtask

	// stop requests, let every pending row verdict come out and the pipe settle
	task automatic wait_rows_out();
		pixels_ch.valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly values that make cuts likely, sometimes the register extremes
	function automatic int unsigned pick(int unsigned top, int unsigned usual);
		case ($urandom_range(0, 7))
			0: return 0;
			1: return top;
			default: return $urandom_range(0, usual);
		endcase
	endfunction

	task automatic shuffle_config();
		if ($urandom_range(0, 1))
			write_reg(CFG_ENABLE, CFG_DATA_W'($urandom_range(0, 5) != 0));
		if ($urandom_range(0, 1))
			write_reg(CFG_STEP_LIMIT, CFG_DATA_W'(pick(65535, 4000)));
		if ($urandom_range(0, 1))
			write_reg(CFG_RUN_LIMIT, CFG_DATA_W'(pick(32'(RUN_MAX), 5)));
		if ($urandom_range(0, 1))
			write_reg(CFG_ROW_SUM_LIMIT, CFG_DATA_W'(pick(32'(SUM_MAX), 400000)));
		if ($urandom_range(0, 1))
			write_reg(CFG_NOISY_RUN_LIMIT, CFG_DATA_W'(pick(1023, 4)));
		if ($urandom_range(0, 1))
			write_reg(CFG_EXTRA_ROWS, CFG_DATA_W'(pick(1023, 6)));
		wr_en <= 1'b0;
	endtask

	// next depth of a row in the given style; the odd pixel is invalid
	function automatic logic [DEPTH_W-1:0] next_depth(row_style_t style,
		logic [DEPTH_W-1:0] prev);
		int v;
		if ($urandom_range(0, 15) == 0)
			return '0;
		case (style)
			ROW_SMOOTH: begin
				v = (prev == 0) ? $urandom_range(300, 10000)
					: int'(prev) + $urandom_range(0, 100) - 50;
				if (v < 1) v = 1;
				if (v > 65535) v = 65535;
			end
			// falling staircase, feeds the artifact step counter
			ROW_STAIRS: v = (prev < 3000) ? $urandom_range(30000, 65535)
				: int'(prev) - int'($urandom_range(0, 3000));
			ROW_SPARSE: v = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 65535);
			default: v = $urandom_range(0, 65535);
		endcase
		return v[DEPTH_W-1:0];
	endfunction

	function automatic int row_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
	endfunction

	task automatic send_row(int len, bit eor_last, bit eof_last);
		row_style_t         style;
		logic [DEPTH_W-1:0] depth;
		depth = '0;
		style = row_style_t'($urandom_range(0, 3));
		for (int i = 0; i < len; i++) begin
			depth = next_depth(style, depth);
			send_pixel(depth, (i == len - 1) && eor_last, (i == len - 1) && eof_last);
		end
	endtask

	// a frame of rows; left open it stops on a plain row end
	task automatic send_frame(bit close);
		int rows;
		rows = $urandom_range(1, 10);
		for (int r = 0; r < rows; r++) begin
			if (r == rows - 1 && close)
				// frame end without row end now and then
				send_row(row_len(), $urandom_range(0, 2) != 0, 1'b1);
			else
				send_row(row_len(), 1'b1, 1'b0);
		end
	endtask

	// loose markers, random depths; closes on a row end so the phase can end idle
	task automatic send_noise(int n);
		bit eor;
		bit eof;
		for (int i = 0; i < n; i++) begin
			eor = ($urandom_range(0, 4) == 0);
			eof = ($urandom_range(0, 15) == 0);
			if (i == n - 1 && !eor && !eof)
				eor = 1'b1;
			send_pixel(DEPTH_W'($urandom_range(0, 65535)), eor, eof);
		end
	endtask

	// row verdict monitor
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rows_ch.valid === 1'b1 && rows_ch.ready === 1'b1)
			board.check_row('{row_number: rows_ch.row_number, row_blank: rows_ch.row_blank,
				cut_found: rows_ch.cut_found, cut_start_row: rows_ch.cut_start_row,
				last: rows_ch.last});
	end

	// receiver: short random stalls, or one long hold-off on demand
	initial begin
		int burst;
		burst = 0;
		rows_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rows_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				rows_ch.ready <= 1'b1;
			end else if (burst > 0) begin
				rows_ch.ready <= 1'b0;
				burst--;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 3);
				rows_ch.ready <= 1'b0;
			end else begin
				rows_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake and no write
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pixels_ch.valid && pixels_ch.ready) || (rows_ch.valid && rows_ch.ready) || wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int base;
		int phase;
		board = new();
		pixels_ch.valid        = 1'b0;
		pixels_ch.depth_mm     = '0;
		pixels_ch.end_of_row   = 1'b0;
		pixels_ch.end_of_frame = 1'b0;
		wr_en    = 1'b0;
		wr_index = CFG_ENABLE;
		wr_data  = '0;
		arst_n   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: invalid one-pixel row, step then step back, invalid break
		send_pixel(16'd0, 1'b1, 1'b0);
		send_pixel(16'd1000, 1'b0, 1'b0);
		send_pixel(16'd500, 1'b0, 1'b0);
		send_pixel(16'hFFFF, 1'b0, 1'b0);
		send_pixel(16'd0, 1'b0, 1'b0);
		send_pixel(16'd300, 1'b1, 1'b0);
		send_pixel(16'hFFFF, 1'b0, 1'b0);
		send_pixel(16'd1, 1'b0, 1'b0);
		send_pixel(16'd0, 1'b1, 1'b1);

		// low extremes: first row stops and cuts, start clamped at zero, rows after it
		// blanked, frame end without row end
		wait_rows_out();
		write_reg(CFG_ENABLE, 1);
		write_reg(CFG_STEP_LIMIT, 0);
		write_reg(CFG_RUN_LIMIT, 0);
		write_reg(CFG_ROW_SUM_LIMIT, 0);
		write_reg(CFG_NOISY_RUN_LIMIT, 0);
		write_reg(CFG_EXTRA_ROWS, 1023);
		wr_en <= 1'b0;
		send_pixel(16'hFFFF, 1'b0, 1'b0);
		send_pixel(16'd1, 1'b1, 1'b0);
		send_pixel(16'd0, 1'b1, 1'b0);
		send_pixel(16'd7, 1'b0, 1'b1);

		// high extremes with the classifier switched off
		wait_rows_out();
		write_reg(CFG_ENABLE, 0);
		write_reg(CFG_STEP_LIMIT, 65535);
		write_reg(CFG_RUN_LIMIT, CFG_DATA_W'(RUN_MAX));
		write_reg(CFG_ROW_SUM_LIMIT, CFG_DATA_W'(SUM_MAX));
		write_reg(CFG_NOISY_RUN_LIMIT, 1023);
		write_reg(CFG_EXTRA_ROWS, 0);
		wr_en <= 1'b0;
		send_pixel(16'd5, 1'b0, 1'b0);
		send_pixel(16'd60000, 1'b1, 1'b0);
		send_pixel(16'd1, 1'b1, 1'b1);

		// one wide row whose sum lands just above the noisy limit
		wait_rows_out();
		write_reg(CFG_ENABLE, 1);
		write_reg(CFG_ROW_SUM_LIMIT, CFG_DATA_W'(WIDE_SUM - 1));
		write_reg(CFG_NOISY_RUN_LIMIT, 0);
		wr_en <= 1'b0;
		for (int i = 0; i < WIDE_PIXELS; i++)
			send_pixel(i[0] ? 16'd1 : 16'hFFFF, i == WIDE_PIXELS - 1, i == WIDE_PIXELS - 1);

		// a frame of one-pixel rows, long enough for the row counter to wrap
		wait_rows_out();
		shuffle_config();
		for (int r = 0; r < WRAP_ROWS; r++)
			send_row(1, 1'b1, r == WRAP_ROWS - 1);

		// random phases, each one on fresh settings after the pipe has emptied
		base  = pixel_count;
		phase = 0;
		while (pixel_count - base < RANDOM_ITEMS) begin
			wait_rows_out();
			shuffle_config();
			tx_idle = ($urandom_range(0, 2) != 0);
			rx_idle = ($urandom_range(0, 2) != 0);
			if (phase == 0) begin
				// receiver holds off while one-pixel rows keep coming, the queue fills
				// and the pixel side has to stall
				tx_idle   = 1'b0;
				long_hold = 1'b1;
				for (int i = 0; i < 40; i++)
					send_pixel(DEPTH_W'($urandom_range(0, 65535)), 1'b1, 1'b0);
			end else if ($urandom_range(0, 4) == 0) begin
				send_noise($urandom_range(5, 40));
			end else begin
				repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 3) != 0);
			end
			phase++;
		end

		// last stretch at full rate on both sides
		wait_rows_out();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		shuffle_config();
		repeat (3) send_frame(1'b1);
		wait_rows_out();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (board.errors == 0 && board.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
